// File: src/npti_pkg.sv
package npti_pkg;

	localparam int COORD_W = 24;
	localparam int IDX_W = 12;
	localparam int TGT_W = 8;
	localparam int DIST_W = 50;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      last_point;
	} point_item_t;

	typedef struct packed {
		logic [TGT_W-1:0]  target_index;
		logic              on_segment;
		logic [DIST_W-1:0] best_distance_sq;
	} result_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} pt_t;

	// One unit of work for the back part: an optional segment test from p to c
	// (followed by the node test of p), and an optional final node test of c.
	typedef struct packed {
		pt_t              p;
		pt_t              c;
		logic             seg;
		logic             fin;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] last_idx;
	} job_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_MUL,
		BK_CHK,
		BK_DIVI,
		BK_DIV,
		BK_SUPD,
		BK_NODE,
		BK_FNODE,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic pop;
		logic out_load;
	} back_ctl_t;

endpackage

// File: src/nearest_polyline_target_index.sv
// Channel  | Direction | Handshake                    | Item
// point    | in        | point_valid / point_stall    | point_item_t, one polyline point
// result   | out       | result_valid / result_stall  | result_item_t, one per polyline
// cfg      | in        | cfg_we, cfg_index, cfg_data  | query_x, query_y, query_z
//
// A job takes the back part longer when the projection lands inside the segment than when it
// misses the segment, since the serial divider then runs and gives one quotient bit a cycle;
// a last point adds a final node test, or is that test alone, before the hand-off.
// All products go through one shared 26 by 26 multiplier, one product a cycle.
// Reset clears the query, the queue, the running best and the result valid flag.
// A stalled result item holds the back part while the front keeps filling the two-entry queue.
module nearest_polyline_target_index #(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 point_valid,
	output logic                                 point_stall,
	input  npti_pkg::point_item_t                point,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output npti_pkg::result_item_t               result,
	input  logic                                 cfg_we,
	input  logic [npti_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [npti_pkg::CFG_W-1:0]           cfg_data
);
	import npti_pkg::*;

	// The query is held sign extended from its low COORD_BITS bits, as every
	// coordinate is used.
	pt_t       query_q;
	logic signed [COORD_BITS-1:0] cfg_low;
	job_t      push_job;
	job_t      head_job;
	logic      push;
	logic      full;
	logic      empty;
	back_ctl_t ctl;

	assign cfg_low = cfg_data[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUERY_X: query_q.x <= COORD_W'(cfg_low);
				REG_QUERY_Y: query_q.y <= COORD_W'(cfg_low);
				REG_QUERY_Z: query_q.z <= COORD_W'(cfg_low);
				default: begin
				end
			endcase
		end
	end

	// The front part tracks the previous point and the count, and turns each point
	// into at most one job for the back part.
	npti_front #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point      (point),
		.push       (push),
		.job        (push_job),
		.full       (full)
	);

	npti_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(push_job),
		.pop    (ctl.pop),
		.rd_data(head_job),
		.full   (full),
		.empty  (empty)
	);

	// The back part scores segments and nodes, keeps the running best and
	// delivers the result item when the polyline closes.
	npti_back #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.query       (query_q),
		.empty       (empty),
		.job         (head_job),
		.ctl         (ctl),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// File: src/npti_front.sv
module npti_front #(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_stall,
	input  npti_pkg::point_item_t point,
	output logic                 push,
	output npti_pkg::job_t       job,
	input  logic                 full
);
	import npti_pkg::*;

	localparam int CNTW = $clog2(MAX_POINTS + 1);

	logic [CNTW-1:0] count_q;
	logic            have_prev_q;
	pt_t             prev_q;
	pt_t             cur;
	logic            take;
	logic            room;
	logic signed [COORD_BITS-1:0] tx, ty, tz;

	assign point_stall = full;
	assign take = point_valid && !full;
	assign room = count_q < CNTW'(MAX_POINTS);

	assign tx = point.point_x[COORD_BITS-1:0];
	assign ty = point.point_y[COORD_BITS-1:0];
	assign tz = point.point_z[COORD_BITS-1:0];
	assign cur.x = COORD_W'(tx);
	assign cur.y = COORD_W'(ty);
	assign cur.z = COORD_W'(tz);

	always_comb begin
		job.p = prev_q;
		job.c = room ? cur : prev_q;
		job.seg = room && have_prev_q;
		job.fin = point.last_point;
		job.idx = IDX_W'(count_q - CNTW'(1));
		job.last_idx = room ? IDX_W'(count_q) : IDX_W'(count_q - CNTW'(1));
		push = take && (job.seg || job.fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			have_prev_q <= 1'b0;
			prev_q <= '0;
		end else if (take) begin
			if (point.last_point) begin
				count_q <= '0;
				have_prev_q <= 1'b0;
				prev_q <= '0;
			end else if (room) begin
				count_q <= count_q + CNTW'(1);
				have_prev_q <= 1'b1;
				prev_q <= cur;
			end
		end
	end

endmodule

// File: src/npti_fifo.sv
module npti_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  npti_pkg::job_t wr_data,
	input  logic           pop,
	output npti_pkg::job_t rd_data,
	output logic           full,
	output logic           empty
);
	import npti_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full = fill_q == 2'd2;
	assign empty = fill_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: src/npti_back.sv
module npti_back #(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  npti_pkg::pt_t          query,
	input  logic                   empty,
	input  npti_pkg::job_t         job,
	output npti_pkg::back_ctl_t    ctl,
	output logic                   result_valid,
	input  logic                   result_stall,
	output npti_pkg::result_item_t result
);
	import npti_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int DW = COORD_BITS + 1;
	localparam int MW = DW + 1;
	localparam int SW = 2 * DW;
	localparam int DOTW = SW + 1;
	localparam int SQW = 2 * SW;
	localparam int DCW = $clog2(SW + 1);

	// Multiply schedule: squares of w, squares of d, w.d, final node, dot squared.
	localparam logic [3:0] K_WW0 = 4'd0;
	localparam logic [3:0] K_DOT2 = 4'd8;
	localparam logic [3:0] K_FIN0 = 4'd9;
	localparam logic [3:0] K_FIN2 = 4'd11;
	localparam logic [3:0] K_SQ0 = 4'd12;
	localparam logic [3:0] K_SQ2 = 4'd14;

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [3:0]  k_q;
	logic [SW-1:0] ww_q, dd_q, q_q, r_q, num_q;
	logic signed [DOTW-1:0] dot_q;
	logic [SQW-1:0] sq_q;
	logic [DCW-1:0] dcnt_q;
	logic [DIST_W-1:0] best_q;
	logic [IW-1:0] best_idx_q;
	logic          best_seg_q;

	logic signed [COORD_BITS-1:0] px, py, pz, cx, cy, cz, qx, qy, qz;
	logic signed [DW-1:0] wx, wy, wz, dx, dy, dz, fx, fy, fz;
	logic signed [MW-1:0] ma, mb;
	logic signed [2*MW-1:0] prod;
	logic [SW-1:0] dotu;
	logic seg_ok;
	logic out_free;
	logic [SW:0] rs;
	logic [SW-1:0] score;
	logic node_better;
	logic [IW:0] tgt_raw, tgt_lim, tgt;

	assign px = job_q.p.x[COORD_BITS-1:0];
	assign py = job_q.p.y[COORD_BITS-1:0];
	assign pz = job_q.p.z[COORD_BITS-1:0];
	assign cx = job_q.c.x[COORD_BITS-1:0];
	assign cy = job_q.c.y[COORD_BITS-1:0];
	assign cz = job_q.c.z[COORD_BITS-1:0];
	assign qx = query.x[COORD_BITS-1:0];
	assign qy = query.y[COORD_BITS-1:0];
	assign qz = query.z[COORD_BITS-1:0];

	assign wx = DW'(qx) - DW'(px);
	assign wy = DW'(qy) - DW'(py);
	assign wz = DW'(qz) - DW'(pz);
	assign dx = DW'(cx) - DW'(px);
	assign dy = DW'(cy) - DW'(py);
	assign dz = DW'(cz) - DW'(pz);
	assign fx = DW'(qx) - DW'(cx);
	assign fy = DW'(qy) - DW'(cy);
	assign fz = DW'(qz) - DW'(cz);

	assign dotu = dot_q[SW-1:0];

	always_comb begin
		case (k_q)
			4'd0:    begin ma = MW'(wx); mb = MW'(wx); end
			4'd1:    begin ma = MW'(wy); mb = MW'(wy); end
			4'd2:    begin ma = MW'(wz); mb = MW'(wz); end
			4'd3:    begin ma = MW'(dx); mb = MW'(dx); end
			4'd4:    begin ma = MW'(dy); mb = MW'(dy); end
			4'd5:    begin ma = MW'(dz); mb = MW'(dz); end
			4'd6:    begin ma = MW'(wx); mb = MW'(dx); end
			4'd7:    begin ma = MW'(wy); mb = MW'(dy); end
			4'd8:    begin ma = MW'(wz); mb = MW'(dz); end
			4'd9:    begin ma = MW'(fx); mb = MW'(fx); end
			4'd10:   begin ma = MW'(fy); mb = MW'(fy); end
			4'd11:   begin ma = MW'(fz); mb = MW'(fz); end
			4'd12: begin
				ma = $signed({1'b0, dotu[DW-1:0]});
				mb = $signed({1'b0, dotu[DW-1:0]});
			end
			4'd13: begin
				ma = $signed({1'b0, dotu[DW-1:0]});
				mb = $signed({1'b0, dotu[SW-1:DW]});
			end
			4'd14: begin
				ma = $signed({1'b0, dotu[SW-1:DW]});
				mb = $signed({1'b0, dotu[SW-1:DW]});
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign prod = ma * mb;

	assign seg_ok = (dot_q > 0) && ($unsigned(dot_q) <= {1'b0, dd_q});
	assign out_free = !result_valid || !result_stall;
	assign rs = {r_q, num_q[SW-1]};
	assign score = ww_q - q_q;
	assign node_better = (ww_q != '0) && (DIST_W'(ww_q) < best_q);

	assign tgt_raw = {1'b0, best_idx_q} + (IW + 1)'(best_seg_q);
	assign tgt_lim = {1'b0, job_q.last_idx[IW-1:0]};
	assign tgt = (tgt_raw > tgt_lim) ? tgt_lim : tgt_raw;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (!empty) state_d = BK_MUL;
			BK_MUL: begin
				if (k_q == K_DOT2) begin
					state_d = BK_CHK;
				end else if (k_q == K_FIN2) begin
					state_d = BK_FNODE;
				end else if (k_q == K_SQ2) begin
					state_d = BK_DIVI;
				end
			end
			BK_CHK:   state_d = seg_ok ? BK_MUL : BK_NODE;
			BK_DIVI:  state_d = BK_DIV;
			BK_DIV:   if (dcnt_q == DCW'(1)) state_d = BK_SUPD;
			BK_SUPD:  state_d = BK_NODE;
			BK_NODE:  state_d = job_q.fin ? BK_MUL : BK_IDLE;
			BK_FNODE: state_d = BK_OUT;
			BK_OUT:   if (out_free) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		ctl.pop = (state_q == BK_IDLE) && !empty;
		ctl.out_load = (state_q == BK_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			best_q <= '1;
			best_idx_q <= '0;
			best_seg_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				BK_SUPD: begin
					if (DIST_W'(score) < best_q) begin
						best_q <= DIST_W'(score);
						best_idx_q <= job_q.idx[IW-1:0];
						best_seg_q <= 1'b1;
					end
				end
				BK_NODE: begin
					if (node_better) begin
						best_q <= DIST_W'(ww_q);
						best_idx_q <= job_q.idx[IW-1:0];
						best_seg_q <= 1'b0;
					end
				end
				BK_FNODE: begin
					if (node_better) begin
						best_q <= DIST_W'(ww_q);
						best_idx_q <= job_q.last_idx[IW-1:0];
						best_seg_q <= 1'b0;
					end
				end
				BK_OUT: begin
					if (ctl.out_load) begin
						best_q <= '1;
						best_idx_q <= '0;
						best_seg_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				job_q <= job;
				ww_q <= '0;
				dd_q <= '0;
				dot_q <= '0;
				sq_q <= '0;
				k_q <= job.seg ? K_WW0 : K_FIN0;
			end
			BK_MUL: begin
				k_q <= k_q + 4'd1;
				if (k_q <= 4'd2 || (k_q >= K_FIN0 && k_q <= K_FIN2)) begin
					ww_q <= ww_q + prod[SW-1:0];
				end else if (k_q <= 4'd5) begin
					dd_q <= dd_q + prod[SW-1:0];
				end else if (k_q <= K_DOT2) begin
					dot_q <= dot_q + DOTW'(prod);
				end else if (k_q == K_SQ0) begin
					sq_q <= sq_q + SQW'(prod[SW-1:0]);
				end else if (k_q == 4'd13) begin
					sq_q <= sq_q + (SQW'(prod[SW-1:0]) << (DW + 1));
				end else begin
					sq_q <= sq_q + (SQW'(prod[SW-1:0]) << SW);
				end
			end
			BK_CHK: begin
				k_q <= K_SQ0;
			end
			BK_DIVI: begin
				r_q <= sq_q[SQW-1:SW];
				num_q <= sq_q[SW-1:0];
				q_q <= '0;
				dcnt_q <= DCW'(SW);
			end
			BK_DIV: begin
				if (rs >= {1'b0, dd_q}) begin
					r_q <= SW'(rs - {1'b0, dd_q});
					q_q <= {q_q[SW-2:0], 1'b1};
				end else begin
					r_q <= rs[SW-1:0];
					q_q <= {q_q[SW-2:0], 1'b0};
				end
				num_q <= num_q << 1;
				dcnt_q <= dcnt_q - DCW'(1);
			end
			BK_NODE: begin
				ww_q <= '0;
				k_q <= K_FIN0;
			end
			BK_OUT: begin
				if (ctl.out_load) begin
					result.target_index <= TGT_W'(tgt);
					result.on_segment <= best_seg_q;
					result.best_distance_sq <= best_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/npti_checker.sv
module npti_sva (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_stall,
	input npti_pkg::result_item_t result
);
	import npti_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("stalled result item changed");

	a_none_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.best_distance_sq == '1) |->
			(result.target_index == '0) && !result.on_segment)
		else $error("empty result carries an index");

	a_seg_has_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.on_segment |-> (result.best_distance_sq != '1))
		else $error("segment match without a distance");

endmodule

bind nearest_polyline_target_index npti_sva u_npti_sva (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
